/* hw/rtl/rmf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmf_pkg
// Shared constants and types of the row mode finder: histogram geometry,
// count width and the status handed from the row tracker to the core.
// ----------------------------------------------------------------------------
package rmf_pkg;

   localparam int MAX_WIDTH   = 4096;
   localparam int PIX_W       = 8;
   localparam int BINS        = 1 << PIX_W;
   localparam int CNT_W       = $clog2(MAX_WIDTH + 1);
   localparam int ROW_WIDTH_W = 13;

   typedef logic [PIX_W-1:0] pix_type;
   typedef logic [CNT_W-1:0] cnt_type;

   typedef struct packed {
      logic    last;
      pix_type mode;
   } rmf_row_status_type;

endpackage

/* hw/rtl/row_mode_finder_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// row_mode_finder_core
// Streaming per-row histogram mode of 8-bit pixels.
//
// Pixels enter on the req_ channel (valid/ready), one item per visible pixel
// in row order. After csr row width pixels the row's most frequent value,
// smallest on ties, leaves on the rsp_ channel (valid/ready), and the next
// row starts with an empty histogram. csr_wr_en/csr_wr_data set the row
// width; write it only while no item is in flight.
//
// Throughput: one pixel per cycle while no row-ending pixel is held in the
// update stage. Each pixel does one read-modify-write of its bin in a
// 256-entry RAM: read issued at acceptance, count updated and written back
// the next cycle, with forwarding of the write that overlaps the read.
// A row's mode is loaded into the rsp_ output register from the update stage.
//
// Reset clears the bin valid flags (so every bin reads zero), the update
// stage and output valid flags and the tracker, and sets the row width to
// one. A stalled receiver holds a row-ending pixel, blocking all new pixels.
// ----------------------------------------------------------------------------
module row_mode_finder_core
   import rmf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [PIX_W-1:0]       req_pixel,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [PIX_W-1:0]       rsp_row_mode,
   input  logic                   csr_wr_en,
   input  logic [ROW_WIDTH_W-1:0] csr_wr_data
);

   logic [ROW_WIDTH_W-1:0] row_width_ff;
   logic [BINS-1:0]        bin_valid_ff, bin_valid_in;
   logic                   s1_valid_ff, s1_valid_in;
   pix_type                s1_pixel_ff;
   logic                   fwd_hit_ff;
   cnt_type                fwd_data_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   pix_type                rsp_mode_ff;

   logic                   rd_en;
   cnt_type                rd_data;
   logic                   wr_en;
   cnt_type                count_old;
   cnt_type                count_new;
   cnt_type                eff_width;
   logic [31:0]            width_wide;
   logic                   s1_go;
   rmf_row_status_type     status;

   // effective width: zero counts as one, clamp at the maximum
   always_comb begin
      width_wide = 32'(row_width_ff);
      if (width_wide == 32'd0) begin
         width_wide = 32'd1;
      end
      if (width_wide > 32'(MAX_WIDTH)) begin
         width_wide = 32'(MAX_WIDTH);
      end
      eff_width = CNT_W'(width_wide);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= ROW_WIDTH_W'(1);
      end else if (csr_wr_en) begin
         row_width_ff <= csr_wr_data;
      end
   end

   // hold a row-ending item while the output register is occupied
   assign s1_go     = s1_valid_ff && (!status.last || !rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_go;
   assign rd_en     = req_valid && req_ready;
   assign wr_en     = s1_go && !status.last;

   always_comb begin
      if (!bin_valid_ff[s1_pixel_ff]) begin
         count_old = '0;
      end else if (fwd_hit_ff) begin
         count_old = fwd_data_ff;
      end else begin
         count_old = rd_data;
      end
      if (count_old < CNT_W'(MAX_WIDTH)) begin
         count_new = count_old + CNT_W'(1);
      end else begin
         count_new = count_old;
      end
   end

   rmf_bin_ram #(
      .DEPTH (BINS),
      .WIDTH (CNT_W)
   ) u_bin_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_pixel_ff),
      .wr_data (count_new),
      .rd_en   (rd_en),
      .rd_addr (req_pixel),
      .rd_data (rd_data)
   );

   rmf_tracker u_tracker (
      .clock     (clock),
      .reset     (reset),
      .go        (s1_go),
      .pixel     (s1_pixel_ff),
      .count_new (count_new),
      .eff_width (eff_width),
      .status    (status)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (rd_en) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end

      bin_valid_in = bin_valid_ff;
      if (s1_go) begin
         if (status.last) begin
            bin_valid_in = '0;
         end else begin
            bin_valid_in[s1_pixel_ff] = 1'b1;
         end
      end

      rsp_valid_in = rsp_valid_ff;
      if (s1_go && status.last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         bin_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         bin_valid_ff <= bin_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         s1_pixel_ff <= req_pixel;
         // catch the write that lands in the same cycle as this read
         fwd_hit_ff  <= wr_en && (s1_pixel_ff == req_pixel);
         fwd_data_ff <= count_new;
      end
      if (s1_go && status.last) begin
         rsp_mode_ff <= status.mode;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_row_mode = rsp_mode_ff;

`ifndef NO_ASSERTIONS
   a_row_end_emits: assert property (@(posedge clock) disable iff (reset)
      (s1_go && status.last) |=> rsp_valid_ff)
      else $error("row end did not load the output register");

   a_row_end_clears: assert property (@(posedge clock) disable iff (reset)
      (s1_go && status.last) |=> (bin_valid_ff == '0))
      else $error("bin valid flags not cleared at row end");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (count_new <= CNT_W'(MAX_WIDTH)))
      else $error("bin count above saturation bound");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rd_en && s1_valid_ff) |-> s1_go)
      else $error("update stage overwritten while held");
`endif

endmodule

/* hw/rtl/rmf_bin_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmf_bin_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module rmf_bin_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 13
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/rmf_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmf_tracker
// Row tracker: column position, running best value and count, and the
// row end decision for the item in the update stage.
// ----------------------------------------------------------------------------
module rmf_tracker
   import rmf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               go,
   input  pix_type            pixel,
   input  cnt_type            count_new,
   input  cnt_type            eff_width,
   output rmf_row_status_type status
);

   cnt_type col_ff, col_in;
   cnt_type best_cnt_ff, best_cnt_in;
   pix_type best_val_ff, best_val_in;
   cnt_type col_new;
   cnt_type upd_cnt;
   pix_type upd_val;

   always_comb begin
      if (count_new > best_cnt_ff || (count_new == best_cnt_ff && pixel < best_val_ff)) begin
         upd_cnt = count_new;
         upd_val = pixel;
      end else begin
         upd_cnt = best_cnt_ff;
         upd_val = best_val_ff;
      end

      if (col_ff < CNT_W'(MAX_WIDTH)) begin
         col_new = col_ff + CNT_W'(1);
      end else begin
         col_new = col_ff;
      end

      status.last = (col_new >= eff_width);
      status.mode = upd_val;

      col_in      = col_ff;
      best_cnt_in = best_cnt_ff;
      best_val_in = best_val_ff;
      if (go) begin
         if (status.last) begin
            // start an empty row
            col_in      = '0;
            best_cnt_in = '0;
            best_val_in = '0;
         end else begin
            col_in      = col_new;
            best_cnt_in = upd_cnt;
            best_val_in = upd_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         best_cnt_ff <= '0;
         best_val_ff <= '0;
      end else begin
         col_ff      <= col_in;
         best_cnt_ff <= best_cnt_in;
         best_val_ff <= best_val_in;
      end
   end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for row_mode_finder_core. Pixels go in on req_ and
// row modes come back on rsp_, both with random gaps and stalls. A local
// histogram tracker predicts the mode of every finished row. Directed tests
// cover ties, extreme values, degenerate and oversize widths, width changes
// inside a row and wide rows. A long random run with mostly short rows
// follows.
// ----------------------------------------------------------------------------
module tb_top;
   import rmf_pkg::*;

   localparam int CLK_PERIOD    = 8;
   localparam int SETTLE_CYCLES = 4;
   localparam int RANDOM_PIXELS = 1280;
   localparam int MAX_REPORTS   = 10;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [PIX_W-1:0]       req_pixel;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [PIX_W-1:0]       rsp_row_mode;
   logic                   csr_wr_en;
   logic [ROW_WIDTH_W-1:0] csr_wr_data;

   // histogram tracker of the row in progress
   cnt_type                bin_count [BINS];
   cnt_type                col_count;
   pix_type                lead_pixel;
   cnt_type                lead_count;
   logic [ROW_WIDTH_W-1:0] width_reg;
   pix_type                mode_queue [$];

   int mismatches;
   bit gaps_on;
   bit stalls_on;

   row_mode_finder_core dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_pixel    (req_pixel),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_row_mode (rsp_row_mode),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic void clear_histogram();
      foreach (bin_count[i]) bin_count[i] = '0;
      col_count  = '0;
      lead_pixel = '0;
      lead_count = '0;
   endfunction

   function automatic void account_pixel(pix_type pix);
      cnt_type c;
      int      limit;
      c = bin_count[pix];
      if (c < MAX_WIDTH) c++;
      bin_count[pix] = c;
      // smaller pixel wins a tie
      if (c > lead_count || (c == lead_count && pix < lead_pixel)) begin
         lead_count = c;
         lead_pixel = pix;
      end
      if (col_count < MAX_WIDTH) col_count++;
      limit = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
      if (col_count >= limit) begin
         mode_queue = {mode_queue, lead_pixel};
         clear_histogram();
      end
   endfunction

   task automatic send_pixel(input int pix);
      int gap;
      gap = gaps_on ? $urandom_range(0, 15) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_pixel <= PIX_W'(pix);
      do @(posedge clock); while (!req_ready);
      account_pixel(PIX_W'(pix));
   endtask

   // hold the sender until every row mode is back and the pipe is quiet
   task automatic drain_modes();
      @(negedge clock);
      req_valid <= 1'b0;
      while (mode_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_row_width(input int w);
      drain_modes();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= ROW_WIDTH_W'(w);
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      width_reg = ROW_WIDTH_W'(w);
   endtask

   always @(posedge clock) begin
      pix_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (mode_queue.size() == 0) begin
            if (mismatches < MAX_REPORTS)
               $display("unexpected row mode %0d at %0t", rsp_row_mode, $time);
            mismatches++;
         end else begin
            want = mode_queue.pop_front();
            if (rsp_row_mode !== want) begin
               if (mismatches < MAX_REPORTS)
                  $display("row mode mismatch: expected %0d, got %0d at %0t",
                           want, rsp_row_mode, $time);
               mismatches++;
            end
         end
      end
   end

   initial begin
      int stall;
      rsp_ready = 1'b0;
      forever begin
         stall = stalls_on ? $urandom_range(0, 15) : 0;
         repeat (stall) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
         end
         @(negedge clock);
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && !reset));
      end
   end

   // width stays at its reset value of one: every pixel is a row
   task automatic test_default_width();
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
      send_pixel(8'h00);
      send_pixel(8'hFF);
      send_pixel(8'h55);
      send_pixel(8'hAA);
   endtask

   task automatic test_ties();
      write_row_width(4);
      send_pixel(5);   send_pixel(3);   send_pixel(5); send_pixel(3);
      send_pixel(7);   send_pixel(7);   send_pixel(2); send_pixel(9);
      send_pixel(255); send_pixel(0);   send_pixel(255); send_pixel(0);
      write_row_width(3);
      send_pixel(9);   send_pixel(8);   send_pixel(7);
   endtask

   task automatic test_zero_width();
      write_row_width(0);
      send_pixel(17);
      send_pixel(200);
   endtask

   task automatic test_width_change_mid_row();
      write_row_width(6);
      send_pixel(10); send_pixel(10); send_pixel(20); send_pixel(20);
      // shrink below the columns taken: the next pixel ends the row
      write_row_width(3);
      send_pixel(20);
      write_row_width(8);
      send_pixel(1); send_pixel(1);
      write_row_width(0);
      send_pixel(2);
   endtask

   task automatic test_wide_rows();
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      write_row_width(MAX_WIDTH);
      repeat (64) send_pixel(200);
      // oversize width clamps to the maximum, so the row runs on
      write_row_width((1 << ROW_WIDTH_W) - 1);
      repeat (32) send_pixel($urandom_range(0, 7));
      // shrink to one: the next pixel ends the row
      write_row_width(1);
      send_pixel(3);
   endtask

   task automatic test_random_rows();
      int sent;
      int width;
      int total;
      int style;
      int base;
      int pix;
      sent = 0;
      while (sent < RANDOM_PIXELS) begin
         gaps_on   = $urandom_range(0, 3) != 0;
         stalls_on = $urandom_range(0, 3) != 0;
         case ($urandom_range(0, 9))
            0: width = $urandom_range(0, 8191);
            1: width = $urandom_range(13, 64);
            default: width = $urandom_range(1, 12);
         endcase
         write_row_width(width);
         if (width == 0 || width > 64) begin
            // leave a partial row for the next width to cut short (zero ends every pixel)
            total = $urandom_range(1, 40);
         end else begin
            total = width * $urandom_range(1, 6);
            if ($urandom_range(0, 3) == 0) total += $urandom_range(0, width - 1);
         end
         style = $urandom_range(0, 2);
         base  = $urandom_range(0, 255);
         for (int i = 0; i < total; i++) begin
            case (style)
               0: pix = $urandom_range(0, 255);
               1: pix = base + $urandom_range(0, 3);
               default: pix = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            endcase
            send_pixel(pix);
         end
         sent += total;
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_pixel   = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      mismatches  = 0;
      width_reg   = 1;
      clear_histogram();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_width();
      test_ties();
      test_zero_width();
      test_width_change_mid_row();
      test_wide_rows();
      test_random_rows();
      drain_modes();

      if (mismatches == 0 && mode_queue.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

/* row_mode_finder_core.f */
hw/rtl/rmf_pkg.sv
hw/rtl/rmf_bin_ram.sv
hw/rtl/rmf_tracker.sv
hw/rtl/row_mode_finder_core.sv
tb/tb_top.sv
